>>> hw/rtl/bezier_curve_sampler_assert.svh
// assertion helpers for the curve sampler, clocked on aclk and off during reset
`ifndef BEZIER_CURVE_SAMPLER_ASSERT_SVH
`define BEZIER_CURVE_SAMPLER_ASSERT_SVH

// same-cycle implication
`define BCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bcs_pkg.sv
package bcs_pkg;

    // field widths
    localparam int COORD_W     = 16;
    localparam int CC_W        = 3;
    localparam int CFG_W       = 7;
    localparam int IDX_OUT_W   = 6;
    localparam int IN_DATA_W   = 10 * COORD_W;
    localparam int OUT_DATA_W  = 40;

    // datapath widths
    localparam int COEF_W      = 22;
    localparam int ACC_W       = 40;
    localparam int PART_W      = ACC_W / 2;
    localparam int T_W         = 16;
    localparam int PROD_W      = PART_W + 1 + T_W + 1;
    localparam int LO_PROD_W   = PART_W + T_W;
    localparam int FRAC_SHIFT  = 16;
    localparam int DIV_STEPS   = T_W + 1;

    // control codes and reset values
    localparam logic [CC_W-1:0]  CC_CUBIC         = 3'd4;
    localparam logic [CC_W-1:0]  CC_QUARTIC       = 3'd5;
    localparam logic [CFG_W-1:0] SAMPLE_COUNT_RST = 7'd64;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef coef_t [4:0]               coef_vec_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACCUM,
        ST_FIN
    } state_t;

    // strobes from the sequencer to the shared step unit
    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic accum;
    } step_ctl_t;

    // power-basis coefficients of one coordinate, exact integers in Q8.8
    function automatic coef_vec_t bcs_coefs(input coord_t p0, input coord_t p1,
                                            input coord_t p2, input coord_t p3,
                                            input coord_t p4, input logic quartic);
        coef_t     a0, a1, a2, a3, a4;
        coef_t     d1, s2, s3;
        coef_vec_t c;
        a0 = coef_t'(p0);
        a1 = coef_t'(p1);
        a2 = coef_t'(p2);
        a3 = coef_t'(p3);
        a4 = coef_t'(p4);
        d1 = a1 - a0;
        s2 = a0 - (a1 <<< 1) + a2;
        s3 = (a3 - a0) + (a1 <<< 1) + a1 - (a2 <<< 1) - a2;
        c[0] = a0;
        if (quartic) begin
            c[1] = d1 <<< 2;
            c[2] = (s2 <<< 2) + (s2 <<< 1);
            c[3] = s3 <<< 2;
            c[4] = a0 + a4 - (a1 <<< 2) + (a2 <<< 2) + (a2 <<< 1) - (a3 <<< 2);
        end else begin
            c[1] = (d1 <<< 1) + d1;
            c[2] = (s2 <<< 1) + s2;
            c[3] = s3;
            c[4] = '0;
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/bezier_curve_sampler.sv
// Cubic or quartic Bezier sampler. Each input word carries five 2-D control points in
// Q8.8 (p4 only matters for quartic) and a control count in tuser: 4 selects a cubic,
// 5 a quartic curve, any other count is dropped with no output. For each word the block
// emits N output words, point i at t = i/N, with its index, saturated Q8.8 x and y, and
// tlast on the final point; N is the sample_count register (0 reads as 1, values above
// MAX_SAMPLES read as MAX_SAMPLES), written through cfg_wr_en/cfg_wr_data: the user must
// write it only while idle; the block does not enforce this. All arithmetic runs through
// one shared 21x17 multiplier doing Horner steps, each a MUL_LO, MUL_HI and ACCUM step.
// A word gets the reciprocal of N from a bit-serial divider, then x and y Horner steps per
// point, which the output side can stall. The input is not ready while a word is in progress.
`include "bezier_curve_sampler_assert.svh"

module bezier_curve_sampler
    import bcs_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // control_count
    input  logic [CC_W-1:0]       s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // point_index, curve_x, curve_y, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int NW    = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W = $clog2(MAX_SAMPLES);

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cnt_reg;
    logic [NW-1:0]        n_reg, n_eff;
    logic                 quartic_reg;
    coef_vec_t            cx_reg, cy_reg;

    logic [4:0]           div_cnt_reg;
    logic [NW-1:0]        rem_reg;
    logic [T_W:0]         q_reg;
    logic [NW:0]          rem_sh;
    logic                 div_ge;

    logic [IDX_W-1:0]     idx_reg;
    logic [T_W:0]         t_reg, t_next;
    logic [NW-1:0]        r_reg, r_next;
    logic [NW:0]          r_sum;
    logic                 r_wrap;
    logic                 coord_reg;
    logic [2:0]           k_reg, k_sel, deg;
    coord_t               x_res_reg;

    logic                 m_valid_reg;
    logic [IDX_OUT_W-1:0] m_idx_reg;
    coord_t               m_x_reg, m_y_reg;
    logic                 m_last_reg;

    logic                 cc_ok, s_fire, out_free, is_last, emit;
    step_ctl_t            ctl;
    coef_t                coef_sel;
    coord_t               res;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= SAMPLE_COUNT_RST;
        end else if (cfg_wr_en) begin
            cnt_reg <= cfg_wr_data;
        end
    end

    // effective sample count
    always_comb begin
        if (cnt_reg == '0) begin
            n_eff = NW'(1);
        end else if (cnt_reg > CFG_W'(MAX_SAMPLES)) begin
            n_eff = NW'(MAX_SAMPLES);
        end else begin
            n_eff = cnt_reg[NW-1:0];
        end
    end

    assign cc_ok    = (s_axis_tuser == CC_CUBIC) || (s_axis_tuser == CC_QUARTIC);
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign is_last  = NW'(idx_reg) == n_reg - NW'(1);
    assign deg      = quartic_reg ? 3'd4 : 3'd3;

    // restoring division of 2^16 by N, one quotient bit a cycle
    assign rem_sh = {rem_reg, div_cnt_reg == '0};
    assign div_ge = rem_sh >= {1'b0, n_reg};

    // t = floor(i * 2^16 / N) stepped by quotient and remainder
    assign r_sum  = {1'b0, r_reg} + {1'b0, rem_reg};
    assign r_wrap = r_sum >= {1'b0, n_reg};
    assign r_next = r_wrap ? NW'(r_sum - {1'b0, n_reg}) : r_sum[NW-1:0];
    assign t_next = t_reg + q_reg + (T_W+1)'(r_wrap);

    // next state and strobes
    always_comb begin
        state_next    = state_reg;
        emit          = 1'b0;
        s_axis_tready = 1'b0;
        ctl           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && cc_ok) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                ctl.load   = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                ctl.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                ctl.mul_hi = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                ctl.accum  = 1'b1;
                state_next = (k_reg == '0) ? ST_FIN : ST_MUL_LO;
            end
            ST_FIN: begin
                if (!coord_reg) begin
                    state_next = ST_LOAD;
                end else if (out_free) begin
                    emit       = 1'b1;
                    state_next = is_last ? ST_IDLE : ST_LOAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // coefficient for the current horner step
    assign k_sel    = (state_reg == ST_LOAD) ? deg : k_reg;
    assign coef_sel = coord_reg ? cy_reg[k_sel] : cx_reg[k_sel];

    // sequencer datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && cc_ok) begin
                    cx_reg      <= bcs_coefs(s_axis_tdata[15:0],    s_axis_tdata[47:32],
                                             s_axis_tdata[79:64],   s_axis_tdata[111:96],
                                             s_axis_tdata[143:128],
                                             s_axis_tuser == CC_QUARTIC);
                    cy_reg      <= bcs_coefs(s_axis_tdata[31:16],   s_axis_tdata[63:48],
                                             s_axis_tdata[95:80],   s_axis_tdata[127:112],
                                             s_axis_tdata[159:144],
                                             s_axis_tuser == CC_QUARTIC);
                    quartic_reg <= s_axis_tuser == CC_QUARTIC;
                    n_reg       <= n_eff;
                    rem_reg     <= '0;
                    q_reg       <= '0;
                    div_cnt_reg <= '0;
                end
            end
            ST_DIV: begin
                rem_reg     <= div_ge ? NW'(rem_sh - {1'b0, n_reg}) : rem_sh[NW-1:0];
                q_reg       <= {q_reg[T_W-1:0], div_ge};
                div_cnt_reg <= div_cnt_reg + 5'd1;
                idx_reg     <= '0;
                t_reg       <= '0;
                r_reg       <= '0;
                coord_reg   <= 1'b0;
            end
            ST_LOAD: begin
                k_reg <= deg - 3'd1;
            end
            ST_ACCUM: begin
                if (k_reg != '0) begin
                    k_reg <= k_reg - 3'd1;
                end
            end
            ST_FIN: begin
                if (!coord_reg) begin
                    x_res_reg <= res;
                    coord_reg <= 1'b1;
                end else if (emit) begin
                    idx_reg   <= idx_reg + IDX_W'(1);
                    t_reg     <= t_next;
                    r_reg     <= r_next;
                    coord_reg <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // shared multiply-accumulate unit
    bcs_step_unit u_step (
        .aclk (aclk),
        .ctl  (ctl),
        .coef (coef_sel),
        .t    (t_reg[T_W-1:0]),
        .res  (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_idx_reg  <= IDX_OUT_W'(idx_reg);
            m_x_reg    <= x_res_reg;
            m_y_reg    <= res;
            m_last_reg <= is_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_y_reg, m_x_reg, m_idx_reg};
    assign m_axis_tlast  = m_last_reg;

    // checks
    `BCS_ASSERT_NOW(a_rem_below_n, (state_reg != ST_IDLE && state_reg != ST_DIV), (r_reg < n_reg && rem_reg < n_reg), "sample phase remainder not below sample count")
    `BCS_ASSERT_NOW(a_t_below_one, state_reg == ST_LOAD, !t_reg[T_W], "sample position reached one")
    `BCS_ASSERT_NOW(a_horner_depth, state_reg == ST_MUL_LO, k_reg < deg, "horner step beyond curve degree")
    `BCS_ASSERT_NEXT(a_bad_word_dropped, (s_fire && !cc_ok), s_axis_tready, "word with bad control count started a run")

endmodule

>>> hw/rtl/bcs_step_unit.sv
module bcs_step_unit
    import bcs_pkg::*;
(
    input  logic             aclk,
    input  step_ctl_t        ctl,
    input  coef_t            coef,
    input  logic [T_W-1:0]   t,
    output coord_t           res
);

    logic signed [PART_W:0]     op_a;
    logic signed [T_W:0]        op_b;
    logic signed [PROD_W-1:0]   mul_reg;
    logic [PART_W:0]            lowsh_reg;
    logic [LO_PROD_W:0]         low_sum;
    acc_t                       acc_reg;
    acc_t                       acc_rnd;
    logic signed [ACC_W-FRAC_SHIFT-1:0] q_val;
    logic                       q_ovf;

    // low half of the accumulator is unsigned, high half carries the sign
    assign op_a = ctl.mul_lo ? {1'b0, acc_reg[PART_W-1:0]}
                             : {acc_reg[ACC_W-1], acc_reg[ACC_W-1:PART_W]};
    assign op_b = {1'b0, t};

    // low partial product rounded at bit 16
    assign low_sum = {1'b0, mul_reg[LO_PROD_W-1:0]} + (LO_PROD_W+1)'(1 << (FRAC_SHIFT - 1));

    // shared multiplier, one partial product per cycle while mul_lo or mul_hi is set
    always_ff @(posedge aclk) begin
        if (ctl.mul_lo || ctl.mul_hi) begin
            mul_reg <= op_a * op_b;
        end
        if (ctl.mul_hi) begin
            lowsh_reg <= low_sum[LO_PROD_W:FRAC_SHIFT];
        end
    end

    // horner accumulator: acc = c << 16 + round(acc * t / 2^16)
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            acc_reg <= acc_t'(coef) <<< FRAC_SHIFT;
        end else if (ctl.accum) begin
            acc_reg <= (acc_t'(coef) <<< FRAC_SHIFT)
                     + (acc_t'(mul_reg) <<< (PART_W - FRAC_SHIFT))
                     + acc_t'(lowsh_reg);
        end
    end

    // back to Q8.8 with rounding, then saturate
    assign acc_rnd = acc_reg + acc_t'(1 << (FRAC_SHIFT - 1));
    assign q_val   = acc_rnd[ACC_W-1:FRAC_SHIFT];
    assign q_ovf   = !((&q_val[ACC_W-FRAC_SHIFT-1:COORD_W-1])
                    || !(|q_val[ACC_W-FRAC_SHIFT-1:COORD_W-1]));

    always_comb begin
        if (!q_ovf) begin
            res = q_val[COORD_W-1:0];
        end else if (q_val[ACC_W-FRAC_SHIFT-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

endmodule
